@@ src/mgp_pkg.sv @@
// ----------------------------------------------------------------------------
// mgp_pkg
// Shared types and constants for the selectable PRNG bank.
// ----------------------------------------------------------------------------
package mgp_pkg;

    localparam int unsigned SEL_W  = 3;
    localparam int unsigned SEED_W = 32;
    localparam int unsigned WORD_W = 64;

    // Generator codes; code 7 is treated as splitmix64
    typedef enum logic [SEL_W-1:0] {
        GEN_XORSHIFT32 = 3'd0,
        GEN_MINSTD     = 3'd1,
        GEN_GLIBC      = 3'd2,
        GEN_MSVC       = 3'd3,
        GEN_JAVA48     = 3'd4,
        GEN_PCG32      = 3'd5,
        GEN_SPLITMIX64 = 3'd6
    } gen_sel_t;

    localparam logic KIND_SEED    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [63:0] PCG_MUL    = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC    = 64'd1442695040888963407;
    localparam logic [63:0] JAVA_MUL   = 64'h0000_0005_DEEC_E66D;
    localparam logic [63:0] JAVA_ADD   = 64'h0000_0000_0000_000B;
    localparam logic [63:0] MINSTD_MUL = 64'd48271;
    localparam logic [31:0] MINSTD_MOD = 32'h7FFF_FFFF;
    localparam logic [63:0] GLIBC_MUL  = 64'd1103515245;
    localparam logic [31:0] GLIBC_ADD  = 32'd12345;
    localparam logic [63:0] MSVC_MUL   = 64'd214013;
    localparam logic [31:0] MSVC_ADD   = 32'd2531011;
    localparam logic [63:0] SM_GAMMA   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MIX1    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MIX2    = 64'h94D0_49BB_1331_11EB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_FOLD,
        ST_DONE
    } core_state_t;

    typedef enum logic [1:0] {
        MS_LO,
        MS_CROSS_AB,
        MS_CROSS_BA,
        MS_SUM
    } mul_step_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

endpackage

@@ src/mgp_in_if.sv @@
// ----------------------------------------------------------------------------
// mgp_in_if
// Item channel: seed load or advance request.
// ----------------------------------------------------------------------------
interface mgp_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] seed_value;

    modport source (output valid, output kind, output seed_value, input ready);
    modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

@@ src/mgp_out_if.sv @@
// ----------------------------------------------------------------------------
// mgp_out_if
// Result channel: one random word per advance.
// ----------------------------------------------------------------------------
interface mgp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

@@ src/mgp_mul.sv @@
// ----------------------------------------------------------------------------
// mgp_mul
// Iterative 64x64 multiplier, low 64 bits of the product, built on one
// 32x32 multiplier used over three partial products.
// ----------------------------------------------------------------------------
module mgp_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  mgp_pkg::mul_req_t req,
    output mgp_pkg::mul_rsp_t rsp
);
    import mgp_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    mul_step_t   step_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mul_out;

    always_comb
    begin
        case (step_reg)
            MS_LO:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
            MS_CROSS_AB:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[63:32];
            end
            MS_CROSS_BA:
            begin
                op_a = a_reg[63:32];
                op_b = b_reg[31:0];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        mul_out = {32'h0, op_a} * {32'h0, op_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= MS_LO;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == MS_SUM);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= MS_LO;
            end
            else if (busy_reg)
            begin
                case (step_reg)
                    MS_LO:       step_reg <= MS_CROSS_AB;
                    MS_CROSS_AB: step_reg <= MS_CROSS_BA;
                    MS_CROSS_BA: step_reg <= MS_SUM;
                    default:
                    begin
                        step_reg <= MS_LO;
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // cross terms only contribute their low 32 bits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                MS_LO:
                begin
                    prod_reg <= mul_out;
                end
                MS_CROSS_AB:
                begin
                    acc_reg  <= prod_reg;
                    prod_reg <= mul_out;
                end
                MS_CROSS_BA:
                begin
                    acc_reg  <= acc_reg + {prod_reg[31:0], 32'h0};
                    prod_reg <= mul_out;
                end
                default:
                begin
                    acc_reg <= acc_reg + {prod_reg[31:0], 32'h0};
                end
            endcase
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

@@ src/mgp_core.sv @@
// ----------------------------------------------------------------------------
// mgp_core
// Sequencer and generator state: seeding rules, pre/post processing around
// the shared multiplier, result hold until the output register is free.
// ----------------------------------------------------------------------------
module mgp_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mgp_pkg::SEL_W-1:0]  sel,
    mgp_in_if.sink                     item,
    input  logic                       res_ready,
    output logic                       res_valid,
    output logic [mgp_pkg::WORD_W-1:0] res_word,
    output mgp_pkg::mul_req_t          mul_req,
    input  mgp_pkg::mul_rsp_t          mul_rsp
);
    import mgp_pkg::*;

    core_state_t state_reg, state_next;
    logic        kind_reg, kind_next;
    logic [31:0] narrow_reg, narrow_next;
    logic [63:0] wide_reg, wide_next;
    logic [63:0] word_reg, word_next;
    logic [31:0] fold_reg, fold_next;

    logic [31:0] xs_a, xs_b, xs_val;
    logic [31:0] seed_fold, seed_mod;
    logic [63:0] java_seed;
    logic [63:0] pcg_mix;
    logic [63:0] pcg_rot;
    logic [63:0] sm_state, sm_mix0;
    logic [63:0] product;
    logic [31:0] mstd_fold1, mstd_fold2, mstd_res;
    logic [31:0] lcg_glibc, lcg_msvc;
    logic [63:0] java_next;

    always_comb
    begin
        xs_a   = narrow_reg ^ (narrow_reg << 13);
        xs_b   = xs_a ^ (xs_a >> 17);
        xs_val = xs_b ^ (xs_b << 5);

        // seed mod (2^31-1): one Mersenne fold, then one conditional subtract
        seed_fold = {1'b0, item.seed_value[30:0]} + {31'h0, item.seed_value[31]};
        seed_mod  = (seed_fold >= MINSTD_MOD) ? (seed_fold - MINSTD_MOD) : seed_fold;

        java_seed = {32'h0, item.seed_value} ^ JAVA_MUL;

        // XSH-RR output from the old state
        pcg_mix = ((wide_reg >> 18) ^ wide_reg) >> 27;
        pcg_rot = {pcg_mix[31:0], pcg_mix[31:0]} >> wide_reg[63:59];

        sm_state = wide_reg + SM_GAMMA;
        sm_mix0  = sm_state ^ (sm_state >> 30);

        product    = mul_rsp.product;
        mstd_fold1 = {1'b0, product[30:0]} + {15'h0, product[47:31]};
        mstd_fold2 = {1'b0, fold_reg[30:0]} + {31'h0, fold_reg[31]};
        mstd_res   = (mstd_fold2 >= MINSTD_MOD) ? (mstd_fold2 - MINSTD_MOD) : mstd_fold2;

        lcg_glibc = product[31:0] + GLIBC_ADD;
        lcg_msvc  = product[31:0] + MSVC_ADD;
        java_next = product + JAVA_ADD;
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        narrow_next = narrow_reg;
        wide_next   = wide_reg;
        word_next   = word_reg;
        fold_next   = fold_reg;
        mul_req     = '0;
        item.ready  = (state_reg == ST_IDLE);
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    kind_next = item.kind;
                    if (item.kind == KIND_SEED)
                    begin
                        case (sel)
                            GEN_XORSHIFT32:
                                narrow_next = (item.seed_value == '0) ? 32'd1 : item.seed_value;
                            GEN_MINSTD:
                                narrow_next = (seed_mod == '0) ? 32'd1 : seed_mod;
                            GEN_GLIBC, GEN_MSVC:
                                narrow_next = item.seed_value;
                            GEN_JAVA48:
                                wide_next = {16'h0, java_seed[47:0]};
                            GEN_PCG32:
                            begin
                                // first step from zero leaves the increment
                                mul_req.start = 1'b1;
                                mul_req.a     = PCG_INC + {32'h0, item.seed_value};
                                mul_req.b     = PCG_MUL;
                                state_next    = ST_MUL1;
                            end
                            default:
                                wide_next = {32'h0, item.seed_value};
                        endcase
                    end
                    else
                    begin
                        case (sel)
                            GEN_XORSHIFT32:
                            begin
                                narrow_next = xs_val;
                                word_next   = {32'h0, xs_val};
                                state_next  = ST_DONE;
                            end
                            GEN_MINSTD:
                            begin
                                mul_req.start = 1'b1;
                                mul_req.a     = {32'h0, narrow_reg};
                                mul_req.b     = MINSTD_MUL;
                                state_next    = ST_MUL1;
                            end
                            GEN_GLIBC:
                            begin
                                mul_req.start = 1'b1;
                                mul_req.a     = {32'h0, narrow_reg};
                                mul_req.b     = GLIBC_MUL;
                                state_next    = ST_MUL1;
                            end
                            GEN_MSVC:
                            begin
                                mul_req.start = 1'b1;
                                mul_req.a     = {32'h0, narrow_reg};
                                mul_req.b     = MSVC_MUL;
                                state_next    = ST_MUL1;
                            end
                            GEN_JAVA48:
                            begin
                                mul_req.start = 1'b1;
                                mul_req.a     = wide_reg;
                                mul_req.b     = JAVA_MUL;
                                state_next    = ST_MUL1;
                            end
                            GEN_PCG32:
                            begin
                                word_next     = {32'h0, pcg_rot[31:0]};
                                mul_req.start = 1'b1;
                                mul_req.a     = wide_reg;
                                mul_req.b     = PCG_MUL;
                                state_next    = ST_MUL1;
                            end
                            default:
                            begin
                                wide_next     = sm_state;
                                mul_req.start = 1'b1;
                                mul_req.a     = sm_mix0;
                                mul_req.b     = SM_MIX1;
                                state_next    = ST_MUL1;
                            end
                        endcase
                    end
                end
            end

            ST_MUL1:
            begin
                if (mul_rsp.done)
                begin
                    case (sel)
                        GEN_XORSHIFT32:
                            state_next = ST_IDLE;
                        GEN_MINSTD:
                        begin
                            fold_next  = mstd_fold1;
                            state_next = ST_FOLD;
                        end
                        GEN_GLIBC:
                        begin
                            narrow_next = lcg_glibc;
                            word_next   = {33'h0, lcg_glibc[31:1]};
                            state_next  = ST_DONE;
                        end
                        GEN_MSVC:
                        begin
                            narrow_next = lcg_msvc;
                            word_next   = {49'h0, lcg_msvc[30:16]};
                            state_next  = ST_DONE;
                        end
                        GEN_JAVA48:
                        begin
                            wide_next  = {16'h0, java_next[47:0]};
                            word_next  = {32'h0, java_next[47:16]};
                            state_next = ST_DONE;
                        end
                        GEN_PCG32:
                        begin
                            wide_next  = product + PCG_INC;
                            state_next = (kind_reg == KIND_ADVANCE) ? ST_DONE : ST_IDLE;
                        end
                        default:
                        begin
                            mul_req.start = 1'b1;
                            mul_req.a     = product ^ (product >> 27);
                            mul_req.b     = SM_MIX2;
                            state_next    = ST_MUL2;
                        end
                    endcase
                end
            end

            ST_MUL2:
            begin
                if (mul_rsp.done)
                begin
                    word_next  = product ^ (product >> 31);
                    state_next = ST_DONE;
                end
            end

            ST_FOLD:
            begin
                narrow_next = mstd_res;
                word_next   = {32'h0, mstd_res};
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            kind_reg   <= KIND_SEED;
            narrow_reg <= '0;
            wide_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            narrow_reg <= narrow_next;
            wide_reg   <= wide_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        fold_reg <= fold_next;
    end

    assign res_word = word_reg;

endmodule

@@ src/multi_generator_prng.sv @@
// ----------------------------------------------------------------------------
// multi_generator_prng
// Selectable PRNG bank: xorshift32, minstd, glibc/msvc LCG, java48, pcg32,
// splitmix64 behind one iterative 64-bit multiplier.
//
// Usage:
//   cfg_we/cfg_wdata write generator_select; write only while idle.
//   item channel: kind 0 loads seed_value with the generator's seeding rule
//   (no result); kind 1 advances and yields one random_word on result.
//   The core takes one item at a time: it accepts the next only when idle.
//   A 64-bit multiply is three 32x32 steps and a final add plus one handoff.
//   Seeding uses no multiply but for pcg32; advancing uses none for
//   xorshift32, two dependent ones for splitmix64 and one for the rest.
//   Result passes from the core's word register to the output register once that is free.
//   Reset: generator_select 0, both state words 0, channels empty.
//   A stalled receiver holds the output register; the core can finish one
//   more item and then waits until the register is free.
// ----------------------------------------------------------------------------
module multi_generator_prng (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [mgp_pkg::SEL_W-1:0] cfg_wdata,
    mgp_in_if.sink                    item,
    mgp_out_if.source                 result
);
    import mgp_pkg::*;

    logic [SEL_W-1:0]  sel_reg;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg;
    logic              core_res_valid;
    logic              core_res_ready;
    logic [WORD_W-1:0] core_res_word;
    logic              out_load;
    mul_req_t          mul_req;
    mul_rsp_t          mul_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= GEN_XORSHIFT32;
        else if (cfg_we)
            sel_reg <= cfg_wdata;
    end

    mgp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    mgp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel       (sel_reg),
        .item      (item),
        .res_ready (core_res_ready),
        .res_valid (core_res_valid),
        .res_word  (core_res_word),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp)
    );

    assign core_res_ready = !out_valid_reg || result.ready;
    assign out_load       = core_res_valid && core_res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_word_reg <= core_res_word;
    end

    assign result.valid       = out_valid_reg;
    assign result.random_word = out_word_reg;

    // core waits for each product, so starts are never adjacent
    a_mul_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |=> !mul_req.start)
        else $error("multiplier restarted while busy");

    // a product only returns while the core is waiting for it
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> !item.ready)
        else $error("product returned while core idle");

    // a finished result blocked by a full output register is held
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        core_res_valid && !core_res_ready |=> core_res_valid && $stable(core_res_word))
        else $error("core result dropped under stall");

endmodule
